[src/lcwr_pkg.sv]
// ----------------------------------------------------------------------------
// lcwr_pkg
// Shared constants, register codes and types of the load-cell weigh reader.
// ----------------------------------------------------------------------------
package lcwr_pkg;

    localparam int CODE_BITS    = 24;
    localparam int TARE_SAMPLES = 5;
    localparam int TARE_MEDIAN  = TARE_SAMPLES / 2;
    localparam int FILL_W       = $clog2(TARE_SAMPLES + 1);
    localparam int PC_W         = $clog2(CODE_BITS + 1);

    localparam int HALF_W   = 16;
    localparam int RECIP_W  = 24;
    localparam int LIMIT_W  = 24;
    localparam int WEIGHT_W = 24;
    localparam int PROD_W   = CODE_BITS + RECIP_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RECIP  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LIMIT = CFG_IDX_W'(2);

    localparam logic [HALF_W-1:0]  HALF_RESET  = HALF_W'(50);
    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(81840);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100000);

    typedef logic [CODE_BITS-1:0] t_code;

    typedef struct packed {
        logic  serial_clock;
        logic  done;
        t_code raw;
    } t_seq_res;

    typedef struct packed {
        logic  tare_ready;
        logic  calc;
        t_code diff;
    } t_tare_res;

endpackage

[src/lcwr_in_if.sv]
// ----------------------------------------------------------------------------
// lcwr_in_if
// Input channel: one beat per converter clock tick with the data line level.
// ----------------------------------------------------------------------------
interface lcwr_in_if;
    logic valid;
    logic ready;
    logic data_level;

    modport source (output valid, output data_level, input ready);
    modport sink (input valid, input data_level, output ready);
endinterface

[src/lcwr_out_if.sv]
// ----------------------------------------------------------------------------
// lcwr_out_if
// Result channel: serial clock level, conversion status, raw code and weight.
// ----------------------------------------------------------------------------
interface lcwr_out_if;
    logic                              valid;
    logic                              ready;
    logic                              serial_clock;
    logic                              sample_valid;
    logic [lcwr_pkg::CODE_BITS-1:0]    raw_code;
    logic                              tare_ready;
    logic [lcwr_pkg::WEIGHT_W-1:0]     weight;

    modport source (output valid, output serial_clock, output sample_valid,
                    output raw_code, output tare_ready, output weight, input ready);
    modport sink (input valid, input serial_clock, input sample_valid,
                  input raw_code, input tare_ready, input weight, output ready);
endinterface

[src/lcwr_cfg_if.sv]
// ----------------------------------------------------------------------------
// lcwr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lcwr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lcwr_pkg::CFG_IDX_W-1:0]     index;
    logic [lcwr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[src/load_cell_weigh_reader.sv]
// ----------------------------------------------------------------------------
// load_cell_weigh_reader
// Load-cell converter reader with serial readout, median tare and scaling.
// ----------------------------------------------------------------------------
// Each input beat is one tick carrying the sampled converter data line; the
// block takes one beat per clock cycle unless the result channel stalls, and
// returns one result beat per input beat, in order. The only stall comes from
// the result channel: the three-stage pipeline (sequencer and tare sort, then
// the 24x24 multiply, then the limit and held weight) moves only while its
// last stage can hand on its beat. The first five conversions after reset
// set the tare as their median and report weight zero. Configuration is
// always ready; index 3 is ignored.
module load_cell_weigh_reader (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lcwr_in_if.sink         i_in,
    lcwr_out_if.source      o_out,
    lcwr_cfg_if.sink        i_cfg
);

    logic [lcwr_pkg::HALF_W-1:0]    r_half;
    logic [lcwr_pkg::RECIP_W-1:0]   r_recip;
    logic [lcwr_pkg::LIMIT_W-1:0]   r_limit;

    logic                           advance;
    logic                           accept;
    lcwr_pkg::t_seq_res             seq_res;
    lcwr_pkg::t_tare_res            tare_res;
    lcwr_pkg::t_code                r_held_raw, n_held_raw;

    logic                           r_s1_valid, r_s1_clk, r_s1_done, r_s1_tready, r_s1_calc;
    lcwr_pkg::t_code                r_s1_raw, r_s1_diff;
    logic                           r_s2_valid, r_s2_clk, r_s2_done, r_s2_tready;
    lcwr_pkg::t_code                r_s2_raw;
    logic                           r_out_valid, r_out_clk, r_out_done, r_out_tready;
    lcwr_pkg::t_code                r_out_raw;
    logic [lcwr_pkg::WEIGHT_W-1:0]  weight;

    assign advance     = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && advance;
    assign i_in.ready  = advance;
    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= lcwr_pkg::HALF_RESET;
            r_recip <= lcwr_pkg::RECIP_RESET;
            r_limit <= lcwr_pkg::LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lcwr_pkg::CFG_HALF_PERIOD:  r_half  <= i_cfg.data[lcwr_pkg::HALF_W-1:0];
                lcwr_pkg::CFG_SCALE_RECIP:  r_recip <= i_cfg.data[lcwr_pkg::RECIP_W-1:0];
                lcwr_pkg::CFG_WEIGHT_LIMIT: r_limit <= i_cfg.data[lcwr_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lcwr_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (accept),
        .i_data_level  (i_in.data_level),
        .i_half_period (r_half),
        .o_res         (seq_res)
    );

    lcwr_tare u_tare (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_done  (seq_res.done),
        .i_raw   (seq_res.raw),
        .o_res   (tare_res)
    );

    assign n_held_raw = seq_res.done ? seq_res.raw : r_held_raw;

    // stage 1: sequencer and tare results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_raw  <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_done   <= 1'b0;
            r_s1_calc   <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept;
            r_s1_done  <= accept && seq_res.done;
            r_s1_calc  <= accept && tare_res.calc;
            if (accept) begin
                r_held_raw <= n_held_raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_clk    <= seq_res.serial_clock;
            r_s1_tready <= tare_res.tare_ready;
            r_s1_raw    <= n_held_raw;
            r_s1_diff   <= tare_res.diff;
        end
    end

    lcwr_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_upd    (r_s1_done),
        .i_calc   (r_s1_calc),
        .i_diff   (r_s1_diff),
        .i_recip  (r_recip),
        .i_limit  (r_limit),
        .o_weight (weight)
    );

    // stages 2 and 3: beat fields follow the multiply and limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_clk     <= r_s1_clk;
            r_s2_done    <= r_s1_done;
            r_s2_tready  <= r_s1_tready;
            r_s2_raw     <= r_s1_raw;
            r_out_clk    <= r_s2_clk;
            r_out_done   <= r_s2_done;
            r_out_tready <= r_s2_tready;
            r_out_raw    <= r_s2_raw;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.serial_clock = r_out_clk;
    assign o_out.sample_valid = r_out_done;
    assign o_out.raw_code     = r_out_raw;
    assign o_out.tare_ready   = r_out_tready;
    assign o_out.weight       = weight;

endmodule

[src/lcwr_seq.sv]
// ----------------------------------------------------------------------------
// lcwr_seq
// Serial readout sequencer: waits for data low, clocks out the code bits and
// the gain pulse, and shifts in the converter word.
// ----------------------------------------------------------------------------
module lcwr_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_data_level,
    input  logic [lcwr_pkg::HALF_W-1:0]    i_half_period,
    output lcwr_pkg::t_seq_res             o_res
);

    localparam logic [2:0] PH_WAIT      = 3'd0;
    localparam logic [2:0] PH_SETTLE    = 3'd1;
    localparam logic [2:0] PH_HIGH      = 3'd2;
    localparam logic [2:0] PH_LOW       = 3'd3;
    localparam logic [2:0] PH_GAIN_HIGH = 3'd4;
    localparam logic [2:0] PH_GAIN_LOW  = 3'd5;

    localparam logic [lcwr_pkg::PC_W-1:0] PC_LAST = lcwr_pkg::PC_W'(lcwr_pkg::CODE_BITS);
    localparam lcwr_pkg::t_code SIGN_BIT = lcwr_pkg::t_code'(1) << (lcwr_pkg::CODE_BITS - 1);

    logic [2:0]                         r_phase, n_phase;
    logic [lcwr_pkg::HALF_W-1:0]        r_dc, n_dc;
    logic [lcwr_pkg::PC_W-1:0]          r_pc, n_pc;
    lcwr_pkg::t_code                    r_sw, n_sw;

    logic [lcwr_pkg::HALF_W-1:0]        half_eff;
    logic [lcwr_pkg::HALF_W-1:0]        dc_inc;
    logic                               half_done;
    logic [lcwr_pkg::HALF_W-1:0]        dc_half;
    logic [lcwr_pkg::PC_W-1:0]          pc_tmp;

    always_comb begin
        half_eff  = (i_half_period == '0) ? lcwr_pkg::HALF_W'(1) : i_half_period;
        dc_inc    = r_dc + lcwr_pkg::HALF_W'(1);
        half_done = (dc_inc >= half_eff);
        dc_half   = half_done ? '0 : dc_inc;

        n_phase = r_phase;
        n_dc    = r_dc;
        n_pc    = r_pc;
        n_sw    = r_sw;
        pc_tmp  = r_pc;

        o_res.serial_clock = 1'b0;
        o_res.done         = 1'b0;
        o_res.raw          = r_sw ^ SIGN_BIT;

        case (r_phase)
            PH_SETTLE: begin
                n_dc = dc_half;
                if (half_done) begin
                    n_phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                o_res.serial_clock = 1'b1;
                n_dc = dc_half;
                if (half_done) begin
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                // sample on the first tick after the falling edge
                if (r_dc == '0 && r_pc < PC_LAST) begin
                    n_sw   = {r_sw[lcwr_pkg::CODE_BITS-2:0], i_data_level};
                    pc_tmp = r_pc + lcwr_pkg::PC_W'(1);
                end
                n_pc = pc_tmp;
                n_dc = dc_half;
                if (half_done) begin
                    n_phase = (pc_tmp < PC_LAST) ? PH_HIGH : PH_GAIN_HIGH;
                end
            end
            PH_GAIN_HIGH: begin
                o_res.serial_clock = 1'b1;
                n_dc = dc_half;
                if (half_done) begin
                    n_phase = PH_GAIN_LOW;
                end
            end
            PH_GAIN_LOW: begin
                n_dc = dc_half;
                if (half_done) begin
                    o_res.done = 1'b1;
                    n_phase    = PH_WAIT;
                    n_pc       = '0;
                    n_sw       = '0;
                end
            end
            default: begin
                n_dc    = '0;
                n_pc    = '0;
                n_sw    = '0;
                n_phase = i_data_level ? PH_WAIT : PH_SETTLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_dc    <= '0;
            r_pc    <= '0;
            r_sw    <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_dc    <= n_dc;
            r_pc    <= n_pc;
            r_sw    <= n_sw;
        end
    end

endmodule

[src/lcwr_tare.sv]
// ----------------------------------------------------------------------------
// lcwr_tare
// Median tare: insertion-sorts the first conversions after reset and takes
// the middle entry as the tare; forms the net difference afterwards.
// ----------------------------------------------------------------------------
module lcwr_tare (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_done,
    input  lcwr_pkg::t_code     i_raw,
    output lcwr_pkg::t_tare_res o_res
);

    localparam logic [lcwr_pkg::FILL_W-1:0] FILL_FULL =
        lcwr_pkg::FILL_W'(lcwr_pkg::TARE_SAMPLES);
    localparam logic [lcwr_pkg::FILL_W-1:0] FILL_LAST =
        lcwr_pkg::FILL_W'(lcwr_pkg::TARE_SAMPLES - 1);

    lcwr_pkg::t_code                    r_sorted [lcwr_pkg::TARE_SAMPLES];
    lcwr_pkg::t_code                    n_sorted [lcwr_pkg::TARE_SAMPLES];
    logic [lcwr_pkg::FILL_W-1:0]        r_fill;
    lcwr_pkg::t_code                    r_tare;

    logic                               full;
    logic                               insert;
    logic [lcwr_pkg::FILL_W-1:0]        slot;

    always_comb begin
        full = (r_fill == FILL_FULL);
        slot = '0;
        // entries at or below the new code stay in place
        for (int i = 0; i < lcwr_pkg::TARE_SAMPLES; i++) begin
            if (lcwr_pkg::FILL_W'(i) < r_fill && r_sorted[i] <= i_raw) begin
                slot = slot + lcwr_pkg::FILL_W'(1);
            end
        end
        insert = i_en && i_done && !full;

        o_res.tare_ready = full || (i_done && r_fill == FILL_LAST);
        o_res.calc       = i_done && full && (i_raw > r_tare);
        o_res.diff       = i_raw - r_tare;
    end

    for (genvar j = 0; j < lcwr_pkg::TARE_SAMPLES; j++) begin : g_ins
        if (j == 0) begin : g_first
            assign n_sorted[j] = (slot == '0) ? i_raw : r_sorted[j];
        end else begin : g_rest
            assign n_sorted[j] = (lcwr_pkg::FILL_W'(j) < slot)  ? r_sorted[j] :
                                 (lcwr_pkg::FILL_W'(j) == slot) ? i_raw : r_sorted[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (insert) begin
            r_sorted <= n_sorted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_tare <= '0;
        end else if (insert) begin
            r_fill <= r_fill + lcwr_pkg::FILL_W'(1);
            if (r_fill == FILL_LAST) begin
                r_tare <= n_sorted[lcwr_pkg::TARE_MEDIAN];
            end
        end
    end

endmodule

[src/lcwr_scale.sv]
// ----------------------------------------------------------------------------
// lcwr_scale
// Weight scaling: net difference times the calibration reciprocal, then the
// range limit; holds the last weight between conversions.
// ----------------------------------------------------------------------------
module lcwr_scale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_upd,
    input  logic                            i_calc,
    input  lcwr_pkg::t_code                 i_diff,
    input  logic [lcwr_pkg::RECIP_W-1:0]    i_recip,
    input  logic [lcwr_pkg::LIMIT_W-1:0]    i_limit,
    output logic [lcwr_pkg::WEIGHT_W-1:0]   o_weight
);

    logic [lcwr_pkg::PROD_W-1:0]    r_prod;
    logic                           r_calc;
    logic                           r_upd;
    logic [lcwr_pkg::WEIGHT_W-1:0]  r_weight, n_weight;
    lcwr_pkg::t_code                w;

    always_comb begin
        w        = r_prod[lcwr_pkg::PROD_W-1:lcwr_pkg::RECIP_W];
        n_weight = r_weight;
        if (r_upd) begin
            n_weight = (r_calc && w <= i_limit) ? lcwr_pkg::WEIGHT_W'(w) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= lcwr_pkg::PROD_W'(i_diff) * lcwr_pkg::PROD_W'(i_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calc   <= 1'b0;
            r_upd    <= 1'b0;
            r_weight <= '0;
        end else if (i_en) begin
            r_calc   <= i_calc;
            r_upd    <= i_upd;
            r_weight <= n_weight;
        end
    end

    assign o_weight = r_weight;

endmodule
